// ----- design/ccpp_pkg.sv -----
// Shared types, codes and decode helpers for the constant pool parser.
// Used by ccpp_parser, ccpp_emitter and class_constant_pool_parser_unit.
`timescale 1ns / 1ps

package ccpp_pkg;

  // Result kinds
  localparam logic [2:0] KIND_ENTRY = 3'd0;
  localparam logic [2:0] KIND_UBYTE = 3'd1;
  localparam logic [2:0] KIND_CONT  = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_TAG  = 2'd1;
  localparam logic [1:0] ERR_LAST_TWO = 2'd2;

  // Constant pool tags
  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE   = 8'd12;

  // Results per input beat at most
  localparam int unsigned MAX_RES = 3;

  // Parse phases, one-hot
  typedef enum logic [6:0] {
    PH_WAIT   = 7'b0000001,
    PH_COUNT  = 7'b0000010,
    PH_TAG    = 7'b0000100,
    PH_FIELDS = 7'b0001000,
    PH_ULEN   = 7'b0010000,
    PH_UBYTES = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] index;
    logic [7:0]  tag;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [15:0] lop;
    logic [7:0]  data;
    logic [1:0]  err;
  } res_t;

  // All results caused by one input beat; cnt of zero means empty
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } grp_t;

  // Fixed field bytes after a tag; zero for Utf8 and unknown tags
  function automatic logic [3:0] fixed_len(input logic [7:0] tag);
    logic [3:0] len;
    len = 4'd0;
    if (tag == TAG_CLASS || tag == TAG_STRING) begin
      len = 4'd2;
    end else if (tag == TAG_INTEGER || tag == TAG_FLOAT || tag == TAG_FIELDREF ||
                 tag == TAG_METHODREF || tag == TAG_IMETHODREF ||
                 tag == TAG_NAMETYPE) begin
      len = 4'd4;
    end else if (tag == TAG_LONG || tag == TAG_DOUBLE) begin
      len = 4'd8;
    end
    return len;
  endfunction

  function automatic logic is_two_slot(input logic [7:0] tag);
    return (tag == TAG_LONG) || (tag == TAG_DOUBLE);
  endfunction

  // Byte at which the second word starts
  function automatic logic [2:0] split_at(input logic [7:0] tag);
    logic [2:0] s;
    s = 3'd4;
    if (tag == TAG_FIELDREF || tag == TAG_METHODREF || tag == TAG_IMETHODREF ||
        tag == TAG_NAMETYPE) begin
      s = 3'd2;
    end
    return s;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [15:0] index,
                                  input logic [7:0] tag, input logic [31:0] v1,
                                  input logic [31:0] v2, input logic [15:0] lop,
                                  input logic [7:0] data, input logic [1:0] err);
    res_t r;
    r.kind         = kind;
    r.index        = index;
    r.tag          = tag;
    r.first_value  = v1;
    r.second_value = v2;
    r.lop          = lop;
    r.data         = data;
    r.err          = err;
    return r;
  endfunction

endpackage

// ----- design/ccpp_parser.sv -----
// Byte parser: holds the parse state and turns one input beat into a group
// of up to three results, registered. Depends on ccpp_pkg.
`timescale 1ns / 1ps

module ccpp_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_start,
  output logic           grp_valid,
  output ccpp_pkg::grp_t grp,
  input  logic           grp_take
);

  ccpp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pool_r, pool_nxt;
  logic [15:0] slot_r, slot_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [31:0] w1_r, w1_nxt;
  logic [31:0] w2_r, w2_nxt;
  logic [15:0] urem_r, urem_nxt;

  ccpp_pkg::grp_t grp_r, grp_nxt;
  logic           grp_valid_r;

  logic       in_fire;
  logic       adv;
  logic [1:0] adv_w;
  logic [3:0] tag_len;
  logic [3:0] cur_len;
  logic       tag_ok;

  assign in_ready  = !grp_valid_r || grp_take;
  assign in_fire   = in_valid && in_ready;
  assign grp_valid = grp_valid_r;
  assign grp       = grp_r;

  assign tag_len = ccpp_pkg::fixed_len(in_byte);
  assign tag_ok  = (tag_len != 4'd0) || (in_byte == ccpp_pkg::TAG_UTF8);
  assign cur_len = ccpp_pkg::fixed_len(tag_r);

  // Next state and the results this beat causes
  always_comb begin
    phase_nxt = phase_r;
    pool_nxt  = pool_r;
    slot_nxt  = slot_r;
    tag_nxt   = tag_r;
    fcnt_nxt  = fcnt_r;
    w1_nxt    = w1_r;
    w2_nxt    = w2_r;
    urem_nxt  = urem_r;
    grp_nxt   = '0;
    adv       = 1'b0;
    adv_w     = 2'd1;

    if (in_start) begin
      // Restart on the high count byte
      phase_nxt = ccpp_pkg::PH_COUNT;
      pool_nxt  = {in_byte, 8'h00};
      slot_nxt  = 16'd1;
      tag_nxt   = 8'd0;
      fcnt_nxt  = 3'd0;
      w1_nxt    = 32'd0;
      w2_nxt    = 32'd0;
      urem_nxt  = 16'd0;
    end else begin
      unique case (phase_r)
        ccpp_pkg::PH_COUNT: begin
          pool_nxt = {pool_r[15:8], in_byte};
          slot_nxt = 16'd1;
          if (pool_nxt <= 16'd1) begin
            grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_DONE, pool_nxt,
                8'd0, 32'd0, 32'd0, 16'd0, 8'd0, ccpp_pkg::ERR_NONE);
            grp_nxt.cnt = grp_nxt.cnt + 2'd1;
            phase_nxt = ccpp_pkg::PH_DONE;
          end else begin
            phase_nxt = ccpp_pkg::PH_TAG;
          end
        end
        ccpp_pkg::PH_TAG: begin
          tag_nxt  = in_byte;
          fcnt_nxt = 3'd0;
          w1_nxt   = 32'd0;
          w2_nxt   = 32'd0;
          if (!tag_ok) begin
            grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_ERR, slot_r,
                in_byte, 32'd0, 32'd0, 16'd0, 8'd0, ccpp_pkg::ERR_BAD_TAG);
            grp_nxt.cnt = grp_nxt.cnt + 2'd1;
            phase_nxt = ccpp_pkg::PH_DONE;
          end else if (ccpp_pkg::is_two_slot(in_byte) &&
                       ({1'b0, slot_r} + 17'd1 >= {1'b0, pool_r})) begin
            // Long or double cannot sit in the final slot
            grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_ERR, slot_r,
                in_byte, 32'd0, 32'd0, 16'd0, 8'd0, ccpp_pkg::ERR_LAST_TWO);
            grp_nxt.cnt = grp_nxt.cnt + 2'd1;
            phase_nxt = ccpp_pkg::PH_DONE;
          end else if (in_byte == ccpp_pkg::TAG_UTF8) begin
            phase_nxt = ccpp_pkg::PH_ULEN;
          end else begin
            phase_nxt = ccpp_pkg::PH_FIELDS;
          end
        end
        ccpp_pkg::PH_FIELDS: begin
          if (fcnt_r < ccpp_pkg::split_at(tag_r)) begin
            w1_nxt = {w1_r[23:0], in_byte};
          end else begin
            w2_nxt = {w2_r[23:0], in_byte};
          end
          if ({1'b0, fcnt_r} + 4'd1 >= cur_len) begin
            grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_ENTRY, slot_r,
                tag_r, w1_nxt, w2_nxt, 16'd0, 8'd0, ccpp_pkg::ERR_NONE);
            grp_nxt.cnt = grp_nxt.cnt + 2'd1;
            adv = 1'b1;
            if (ccpp_pkg::is_two_slot(tag_r)) begin
              grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_CONT,
                  slot_r + 16'd1, tag_r, 32'd0, 32'd0, 16'd0, 8'd0, ccpp_pkg::ERR_NONE);
              grp_nxt.cnt = grp_nxt.cnt + 2'd1;
              adv_w = 2'd2;
            end
          end else begin
            fcnt_nxt = fcnt_r + 3'd1;
          end
        end
        ccpp_pkg::PH_ULEN: begin
          // Length collects in the low half of the first word
          w1_nxt = {16'd0, w1_r[7:0], in_byte};
          if (fcnt_r == 3'd0) begin
            fcnt_nxt = 3'd1;
          end else begin
            urem_nxt = w1_nxt[15:0];
            if (w1_nxt[15:0] == 16'd0) begin
              grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_ENTRY, slot_r,
                  tag_r, 32'd0, 32'd0, 16'd0, 8'd0, ccpp_pkg::ERR_NONE);
              grp_nxt.cnt = grp_nxt.cnt + 2'd1;
              adv = 1'b1;
            end else begin
              phase_nxt = ccpp_pkg::PH_UBYTES;
            end
          end
        end
        ccpp_pkg::PH_UBYTES: begin
          grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_UBYTE, slot_r,
              tag_r, 32'd0, 32'd0, w1_r[15:0] - urem_r, in_byte, ccpp_pkg::ERR_NONE);
          grp_nxt.cnt = grp_nxt.cnt + 2'd1;
          urem_nxt = urem_r - 16'd1;
          if (urem_nxt == 16'd0) begin
            grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_ENTRY, slot_r,
                tag_r, 32'd0, 32'd0, w1_r[15:0], 8'd0, ccpp_pkg::ERR_NONE);
            grp_nxt.cnt = grp_nxt.cnt + 2'd1;
            adv = 1'b1;
          end
        end
        default: begin
          // Waiting for a count or done: drop the beat
        end
      endcase

      // Step past the finished entry; close the pool at the end
      if (adv) begin
        slot_nxt = slot_r + {14'd0, adv_w};
        if (slot_nxt >= pool_r) begin
          grp_nxt.res[grp_nxt.cnt] = ccpp_pkg::mk_res(ccpp_pkg::KIND_DONE, pool_r,
              8'd0, 32'd0, 32'd0, 16'd0, 8'd0, ccpp_pkg::ERR_NONE);
          grp_nxt.cnt = grp_nxt.cnt + 2'd1;
          phase_nxt = ccpp_pkg::PH_DONE;
        end else begin
          phase_nxt = ccpp_pkg::PH_TAG;
        end
      end
    end
  end

  // Advance parse state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ccpp_pkg::PH_WAIT;
      pool_r  <= 16'd0;
      slot_r  <= 16'd1;
      tag_r   <= 8'd0;
      fcnt_r  <= 3'd0;
      w1_r    <= 32'd0;
      w2_r    <= 32'd0;
      urem_r  <= 16'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      pool_r  <= pool_nxt;
      slot_r  <= slot_nxt;
      tag_r   <= tag_nxt;
      fcnt_r  <= fcnt_nxt;
      w1_r    <= w1_nxt;
      w2_r    <= w2_nxt;
      urem_r  <= urem_nxt;
    end
  end

  // Hold the result group until the emitter takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
    end else if (in_fire) begin
      grp_valid_r <= (grp_nxt.cnt != 2'd0);
    end else if (grp_take) begin
      grp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      grp_r <= grp_nxt;
    end
  end

  // A start beat always lands in the count phase
  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_start) |=> (phase_r == ccpp_pkg::PH_COUNT))
    else $error("start beat did not enter count phase");

  // Once done, plain beats produce nothing
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_start && phase_r == ccpp_pkg::PH_DONE) |=> !grp_valid_r)
    else $error("beat after completion produced results");

  // A held group is never empty
  a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid_r |-> (grp_r.cnt != 2'd0))
    else $error("empty result group held");

endmodule

// ----- design/ccpp_emitter.sv -----
// Output stage: takes one result group and hands its results out one beat
// at a time, marking the last. Depends on ccpp_pkg.
`timescale 1ns / 1ps

module ccpp_emitter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           grp_valid,
  input  ccpp_pkg::grp_t grp,
  output logic           grp_take,
  output logic           out_valid,
  input  logic           out_ready,
  output ccpp_pkg::res_t out_res,
  output logic           out_last
);

  ccpp_pkg::grp_t cur_r;
  logic           cur_valid_r;
  logic [1:0]     idx_r;
  logic           out_fire;

  assign out_valid = cur_valid_r;
  assign out_res   = cur_r.res[idx_r];
  assign out_last  = (idx_r == cur_r.cnt - 2'd1);
  assign out_fire  = out_valid && out_ready;
  assign grp_take  = !cur_valid_r || (out_fire && out_last);

  // Load a new group when the current one is finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (grp_take) begin
      cur_valid_r <= grp_valid;
      idx_r       <= 2'd0;
    end else if (out_fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      cur_r <= grp;
    end
  end

  // The read position stays inside the group
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < cur_r.cnt))
    else $error("result index beyond group");

  // A stalled beat keeps its place in the group
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(idx_r)))
    else $error("stalled result moved");

  // Pool complete is always the last result of its group
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.kind == ccpp_pkg::KIND_DONE) |-> out_last)
    else $error("pool complete not last in group");

endmodule

// ----- design/class_constant_pool_parser_unit.sv -----
// Class-file constant pool parser, top level: stream ports around the parser
// and the output stage. Depends on ccpp_pkg, ccpp_parser and ccpp_emitter.
//
// Feed the class file one byte per beat, starting at the pool count with
// in_tuser high on the first count byte (that restarts the parser at any
// time). A byte is taken every cycle while the output is ready and each byte
// yields at most one result; a byte that yields two or three results (a
// finished long/double, the last Utf8 byte, an entry that ends the pool) holds
// the output port while they go out one by one, and the input stalls once the
// one-group buffer between the parser register and the output register is full.
// Results are registered in the parser and again in the output stage. After
// pool complete or an error, bytes are accepted and dropped until the next start.
`timescale 1ns / 1ps

module class_constant_pool_parser_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] start_of_pool
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // [15:0] entry_index, [23:16] entry_tag,
                                   // [55:24] first_value, [87:56] second_value,
                                   // [103:88] utf8_length_or_position,
                                   // [111:104] utf8_data, [113:112] error_code
  output logic [2:0]   out_tuser,  // [2:0] result_kind
  output logic         out_tlast   // last_of_run
);

  ccpp_pkg::grp_t grp;
  ccpp_pkg::res_t res;
  logic           grp_valid;
  logic           grp_take;

  ccpp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take)
  );

  ccpp_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  // Pack the result beat
  assign out_tuser = res.kind;
  assign out_tdata = {6'd0, res.err, res.data, res.lop, res.second_value,
                      res.first_value, res.tag, res.index};

endmodule

// ----- dv/tb_class_constant_pool_parser_unit.sv -----
// Self-checking testbench for class_constant_pool_parser_unit: a byte stream of
// constant pools goes in, and each result beat is checked against a predictor.
// Depends on ccpp_pkg and the class_constant_pool_parser_unit RTL.
`timescale 1ns / 1ps

module tb_class_constant_pool_parser_unit;

  localparam int STIM_BYTES   = 420;
  localparam int CALM_TAIL    = 60;
  localparam int HOLD_AT_BYTE = 150;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] index;
    logic [7:0]  tag;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [15:0] len_or_pos;
    logic [7:0]  str_byte;
    logic [1:0]  err;
    logic        last;
  } pool_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } pool_byte_t;

  // Predicts the results of each byte and checks result beats in order
  class pool_scoreboard;
    ccpp_pkg::phase_t phase;
    logic [15:0]      pool_cnt;
    logic [15:0]      slot;
    logic [7:0]       cur_tag;
    logic [2:0]       field_cnt;
    logic [31:0]      word_hi;
    logic [31:0]      word_lo;
    logic [15:0]      str_left;
    pool_result_t     pending_q[$];
    int               mismatches;

    function new();
      clear_parse();
      phase      = ccpp_pkg::PH_WAIT;
      mismatches = 0;
    endfunction

    function void clear_parse();
      pool_cnt  = 16'd0;
      slot      = 16'd1;
      cur_tag   = 8'd0;
      field_cnt = 3'd0;
      word_hi   = 32'd0;
      word_lo   = 32'd0;
      str_left  = 16'd0;
    endfunction

    // Fixed bytes after the tag; zero for Utf8 and for unknown tags
    static function int field_bytes(logic [7:0] tag);
      case (tag)
        ccpp_pkg::TAG_CLASS, ccpp_pkg::TAG_STRING: return 2;
        ccpp_pkg::TAG_INTEGER, ccpp_pkg::TAG_FLOAT, ccpp_pkg::TAG_FIELDREF,
        ccpp_pkg::TAG_METHODREF, ccpp_pkg::TAG_IMETHODREF,
        ccpp_pkg::TAG_NAMETYPE: return 4;
        ccpp_pkg::TAG_LONG, ccpp_pkg::TAG_DOUBLE: return 8;
        default: return 0;
      endcase
    endfunction

    static function bit takes_two_slots(logic [7:0] tag);
      return (tag == ccpp_pkg::TAG_LONG) || (tag == ccpp_pkg::TAG_DOUBLE);
    endfunction

    function void push_result(logic [2:0] kind, logic [15:0] index, logic [7:0] tag,
                              logic [31:0] v1, logic [31:0] v2, logic [15:0] lop,
                              logic [7:0] sb, logic [1:0] err);
      pool_result_t r;
      r = '{kind, index, tag, v1, v2, lop, sb, err, 1'b0};
      pending_q.push_back(r);
    endfunction

    // Step past the finished entry; close the pool when the slots run out
    function void advance_slot(logic [15:0] width);
      slot = slot + width;
      if (slot >= pool_cnt) begin
        push_result(ccpp_pkg::KIND_DONE, pool_cnt, 8'd0, 32'd0, 32'd0, 16'd0, 8'd0,
                    ccpp_pkg::ERR_NONE);
        phase = ccpp_pkg::PH_DONE;
      end else begin
        phase = ccpp_pkg::PH_TAG;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      int           before_n;
      int           split;
      pool_result_t r;
      before_n = pending_q.size();
      if (start) begin
        clear_parse();
        pool_cnt = {b, 8'h00};
        phase    = ccpp_pkg::PH_COUNT;
        return;
      end
      case (phase)
        ccpp_pkg::PH_COUNT: begin
          pool_cnt = pool_cnt | {8'h00, b};
          slot     = 16'd1;
          if (pool_cnt <= 16'd1) begin
            push_result(ccpp_pkg::KIND_DONE, pool_cnt, 8'd0, 32'd0, 32'd0, 16'd0, 8'd0,
                        ccpp_pkg::ERR_NONE);
            phase = ccpp_pkg::PH_DONE;
          end else begin
            phase = ccpp_pkg::PH_TAG;
          end
        end
        ccpp_pkg::PH_TAG: begin
          cur_tag   = b;
          field_cnt = 3'd0;
          word_hi   = 32'd0;
          word_lo   = 32'd0;
          if (field_bytes(b) == 0 && b != ccpp_pkg::TAG_UTF8) begin
            push_result(ccpp_pkg::KIND_ERR, slot, b, 32'd0, 32'd0, 16'd0, 8'd0,
                        ccpp_pkg::ERR_BAD_TAG);
            phase = ccpp_pkg::PH_DONE;
          end else if (takes_two_slots(b) &&
                       ({1'b0, slot} + 17'd1 >= {1'b0, pool_cnt})) begin
            push_result(ccpp_pkg::KIND_ERR, slot, b, 32'd0, 32'd0, 16'd0, 8'd0,
                        ccpp_pkg::ERR_LAST_TWO);
            phase = ccpp_pkg::PH_DONE;
          end else if (b == ccpp_pkg::TAG_UTF8) begin
            phase = ccpp_pkg::PH_ULEN;
          end else begin
            phase = ccpp_pkg::PH_FIELDS;
          end
        end
        ccpp_pkg::PH_FIELDS: begin
          // Member refs and NameAndType split their four bytes into two u2 halves
          split = (cur_tag >= ccpp_pkg::TAG_FIELDREF &&
                   cur_tag <= ccpp_pkg::TAG_NAMETYPE) ? 2 : 4;
          if (int'(field_cnt) < split) begin
            word_hi = {word_hi[23:0], b};
          end else begin
            word_lo = {word_lo[23:0], b};
          end
          if (int'(field_cnt) + 1 >= field_bytes(cur_tag)) begin
            push_result(ccpp_pkg::KIND_ENTRY, slot, cur_tag, word_hi, word_lo, 16'd0, 8'd0,
                        ccpp_pkg::ERR_NONE);
            if (takes_two_slots(cur_tag)) begin
              push_result(ccpp_pkg::KIND_CONT, slot + 16'd1, cur_tag, 32'd0, 32'd0, 16'd0,
                          8'd0, ccpp_pkg::ERR_NONE);
              advance_slot(16'd2);
            end else begin
              advance_slot(16'd1);
            end
          end else begin
            field_cnt = field_cnt + 3'd1;
          end
        end
        ccpp_pkg::PH_ULEN: begin
          // Hold the string length in the low half of the first word
          word_hi = {16'h0000, word_hi[7:0], b};
          if (field_cnt == 3'd0) begin
            field_cnt = 3'd1;
          end else begin
            str_left = word_hi[15:0];
            if (str_left == 16'd0) begin
              push_result(ccpp_pkg::KIND_ENTRY, slot, cur_tag, 32'd0, 32'd0, 16'd0, 8'd0,
                          ccpp_pkg::ERR_NONE);
              advance_slot(16'd1);
            end else begin
              phase = ccpp_pkg::PH_UBYTES;
            end
          end
        end
        ccpp_pkg::PH_UBYTES: begin
          push_result(ccpp_pkg::KIND_UBYTE, slot, cur_tag, 32'd0, 32'd0,
                      word_hi[15:0] - str_left, b, ccpp_pkg::ERR_NONE);
          str_left = str_left - 16'd1;
          if (str_left == 16'd0) begin
            push_result(ccpp_pkg::KIND_ENTRY, slot, cur_tag, 32'd0, 32'd0, word_hi[15:0],
                        8'd0, ccpp_pkg::ERR_NONE);
            advance_slot(16'd1);
          end
        end
        default: ;
      endcase
      // Flag the final result of this byte
      if (pending_q.size() > before_n) begin
        r = pending_q.pop_back();
        r.last = 1'b1;
        pending_q.push_back(r);
      end
    endfunction

    function string describe(pool_result_t r);
      return $sformatf("kind=%0d idx=%0d tag=%0d v1=%h v2=%h lp=%0d data=%h err=%0d last=%0d",
                       r.kind, r.index, r.tag, r.first_value, r.second_value,
                       r.len_or_pos, r.str_byte, r.err, r.last);
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      bit           bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("[%0t] unexpected result beat: %s", $realtime, describe(got));
        end
        return;
      end
      want = pending_q.pop_front();
      bad  = (got.kind !== want.kind) || (got.index !== want.index) ||
             (got.tag !== want.tag) || (got.first_value !== want.first_value) ||
             (got.second_value !== want.second_value) ||
             (got.len_or_pos !== want.len_or_pos) || (got.str_byte !== want.str_byte) ||
             (got.err !== want.err) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected: %s", describe(want));
          $display("  actual:   %s", describe(got));
        end
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  pool_scoreboard sb;
  pool_byte_t     stim_q[$];
  int             bytes_taken = 0;
  int             tail_start = 0;
  bit             bytes_done = 1'b0;
  int             stall_cycles = 0;

  class_constant_pool_parser_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // Stimulus building
  function automatic void put_byte(logic [7:0] d, logic s = 1'b0);
    pool_byte_t pb;
    pb.data  = d;
    pb.start = s;
    stim_q.push_back(pb);
  endfunction

  function automatic void put_u2(logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endfunction

  function automatic void put_start(logic [15:0] cnt);
    put_byte(cnt[15:8], 1'b1);
    put_byte(cnt[7:0]);
  endfunction

  function automatic logic [7:0] pick_known_tag();
    case ($urandom_range(0, 10))
      0: return ccpp_pkg::TAG_UTF8;
      1: return ccpp_pkg::TAG_INTEGER;
      2: return ccpp_pkg::TAG_FLOAT;
      3: return ccpp_pkg::TAG_LONG;
      4: return ccpp_pkg::TAG_DOUBLE;
      5: return ccpp_pkg::TAG_CLASS;
      6: return ccpp_pkg::TAG_STRING;
      7: return ccpp_pkg::TAG_FIELDREF;
      8: return ccpp_pkg::TAG_METHODREF;
      9: return ccpp_pkg::TAG_IMETHODREF;
      default: return ccpp_pkg::TAG_NAMETYPE;
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_tag();
    logic [7:0] t;
    do begin
      t = 8'($urandom_range(0, 255));
    end while (t == ccpp_pkg::TAG_UTF8 ||
               (t >= ccpp_pkg::TAG_INTEGER && t <= ccpp_pkg::TAG_NAMETYPE));
    return t;
  endfunction

  // One pool: mostly well formed with random content, sometimes noise
  function automatic void add_pool();
    int         mode;
    int         cnt;
    int         slot;
    int         len;
    logic [7:0] tag;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      put_start(16'($urandom_range(0, 65535)));
      repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (mode == 1) begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    cnt = $urandom_range(2, 7);
    put_start(16'(cnt));
    slot = 1;
    while (slot < cnt) begin
      if ($urandom_range(0, 39) == 0) begin
        put_byte(pick_bad_tag());
        break;
      end
      // Cut the pool short; the next start drops it
      if ($urandom_range(0, 29) == 0) break;
      tag = pick_known_tag();
      if (pool_scoreboard::takes_two_slots(tag) && slot + 1 >= cnt &&
          $urandom_range(0, 2) != 0) begin
        tag = ccpp_pkg::TAG_STRING;
      end
      put_byte(tag);
      if (pool_scoreboard::takes_two_slots(tag) && slot + 1 >= cnt) break;
      if (tag == ccpp_pkg::TAG_UTF8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 4);
        put_u2(16'(len));
        repeat (len) put_byte(8'($urandom_range(0, 255)));
        slot++;
      end else begin
        repeat (pool_scoreboard::field_bytes(tag)) put_byte(8'($urandom_range(0, 255)));
        slot += pool_scoreboard::takes_two_slots(tag) ? 2 : 1;
      end
    end
    // Trailing bytes land after completion and are dropped, unless the pool was cut short
    repeat ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_stimulus();
    // Directed: stray byte, empty pools, restart, both errors, empty Utf8, double
    put_byte(8'hA5);
    put_start(16'h0000);
    put_start(16'h0001);
    put_start(16'hFFFF);
    put_byte(ccpp_pkg::TAG_METHODREF);
    put_byte(8'h12);
    put_start(16'h0005);
    put_byte(8'h02);
    put_start(16'h0002);
    put_byte(ccpp_pkg::TAG_LONG);
    put_start(16'h0002);
    put_byte(ccpp_pkg::TAG_UTF8);
    put_u2(16'h0000);
    put_start(16'h0003);
    put_byte(ccpp_pkg::TAG_DOUBLE);
    repeat (8) put_byte(8'hFF);
    while (stim_q.size() < STIM_BYTES) add_pool();
    tail_start = stim_q.size() - CALM_TAIL;
  endfunction

  // Idle bursts stop in calm stretches and in the tail of the run
  function automatic bit idle_allowed(int n);
    return (n < tail_start) && (((n / 48) % 3) != 2);
  endfunction

  // Reset, wait for the stream to finish and drain, then report
  initial begin : run_test
    sb = new();
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (bytes_done);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Send bytes with random idle bursts
  initial begin : drive_bytes
    int gap;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    gap = 0;
    wait (rst_n === 1'b1);
    while (!bytes_done) begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        sb.note_byte(in_tdata, in_tuser);
        bytes_taken++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the beat
      end else if (bytes_taken >= stim_q.size()) begin
        in_tvalid <= 1'b0;
        bytes_done = 1'b1;
      end else if (gap > 0) begin
        in_tvalid <= 1'b0;
        gap--;
      end else if (idle_allowed(bytes_taken) && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        gap = $urandom_range(1, 5) - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= stim_q[bytes_taken].data;
        in_tuser  <= stim_q[bytes_taken].start;
      end
    end
  end

  // Take result beats with random stalls and one long hold-off
  initial begin : drain_results
    int           gap;
    int           hold_left;
    bit           held;
    pool_result_t got;
    out_tready = 1'b0;
    gap        = 0;
    hold_left  = 0;
    held       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.kind         = out_tuser;
        got.index        = out_tdata[15:0];
        got.tag          = out_tdata[23:16];
        got.first_value  = out_tdata[55:24];
        got.second_value = out_tdata[87:56];
        got.len_or_pos   = out_tdata[103:88];
        got.str_byte     = out_tdata[111:104];
        got.err          = out_tdata[113:112];
        got.last         = out_tlast;
        sb.check_result(got);
      end
      if (!held && bytes_taken >= HOLD_AT_BYTE) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else if (idle_allowed(bytes_taken) && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 5) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Count cycles in which neither side moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
